// ===== rtl/core/phr_pkg.sv =====
// ----------------------------------------------------------------------------
// phr_pkg: shared types and constants of the netpbm header parser
// byte classes, parser phases, outcome and result words, error codes
// ----------------------------------------------------------------------------
package phr_pkg;

    // fixed field widths
    localparam int unsigned LEN_W  = 24;
    localparam int unsigned NUM_W  = 16;
    localparam int unsigned DATA_W = 36;
    localparam int unsigned PROD_W = 2 * NUM_W;

    // defaults for top level parameters
    localparam int unsigned MIN_LENGTH   = 10;
    localparam int unsigned TOKEN_DEPTH  = 4;
    localparam int unsigned RESULT_DEPTH = 2;

    // byte order mark needs this many bytes
    localparam int unsigned BOM_LEN = 3;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_BOM0  = 8'hEF;
    localparam logic [7:0] CH_BOM1  = 8'hBB;
    localparam logic [7:0] CH_BOM2  = 8'hBF;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_SHORT   = 3'd1;
    localparam logic [2:0] ERR_MAGIC   = 3'd2;
    localparam logic [2:0] ERR_DIGIT   = 3'd3;
    localparam logic [2:0] ERR_MISSING = 3'd4;
    localparam logic [2:0] ERR_ZERO    = 3'd5;
    localparam logic [2:0] ERR_LARGE   = 3'd6;

    // format digits
    localparam logic [2:0] FMT_P1 = 3'd1;
    localparam logic [2:0] FMT_P2 = 3'd2;
    localparam logic [2:0] FMT_P3 = 3'd3;
    localparam logic [2:0] FMT_P4 = 3'd4;
    localparam logic [2:0] FMT_P5 = 3'd5;
    localparam logic [2:0] FMT_P6 = 3'd6;

    // color modes
    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_GRAY = 2'd1;
    localparam logic [1:0] MODE_RGB  = 2'd2;

    // largest 8-bit sample value
    localparam logic [NUM_W-1:0] SAMPLE_8BIT_MAX = NUM_W'(255);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_BOM1,
        PH_BOM2,
        PH_PRE,
        PH_DIGIT,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_TAIL,
        PH_DONE
    } t_phr_phase;

    typedef struct packed {
        logic [7:0]       byte_value;
        logic [LEN_W-1:0] stream_length;
    } t_phr_in;

    typedef struct packed {
        logic              header_ok;
        logic [2:0]        error_code;
        logic [2:0]        format_digit;
        logic              raw_format;
        logic [1:0]        color_kind;
        logic [NUM_W-1:0]  image_width;
        logic [NUM_W-1:0]  image_height;
        logic [NUM_W-1:0]  max_sample;
        logic [LEN_W-1:0]  header_length;
        logic [DATA_W-1:0] data_length;
    } t_phr_out;

    typedef struct packed {
        logic is_ws;
        logic is_nl;
        logic is_hash;
        logic is_digit;
        logic is_fmt;
        logic is_p;
        logic is_bom0;
        logic is_bom1;
        logic is_bom2;
    } t_phr_class;

    // one classified byte on its way from front to back
    typedef struct packed {
        t_phr_class       cls;
        logic [3:0]       digit;
        logic             first;
        logic             last;
        logic             short_len;
        logic             bom_ok;
        logic [LEN_W-1:0] idx;
        logic [LEN_W-1:0] len;
    } t_phr_token;

    // parser outcome before the data size is worked out
    typedef struct packed {
        logic             ok;
        logic [2:0]       err;
        logic [2:0]       fmt;
        logic [NUM_W-1:0] w;
        logic [NUM_W-1:0] h;
        logic [NUM_W-1:0] m;
        logic [LEN_W-1:0] hl;
    } t_phr_outcome;

endpackage

// ===== rtl/core/phr_queue.sv =====
// ----------------------------------------------------------------------------
// phr_queue: small register fifo
// push blocked while full, pop while empty, head word always on o_data
// ----------------------------------------------------------------------------
module phr_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_push && !o_full;
    assign rd_ok   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (rd_ok) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + CW'(1);
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("phr_queue: fill count beyond depth");

endmodule

// ===== rtl/core/phr_front.sv =====
// ----------------------------------------------------------------------------
// phr_front: byte classifier and length tracker
// latches the image length, marks first and last byte, decodes byte class
// ----------------------------------------------------------------------------
module phr_front #(
    parameter int unsigned MIN_LENGTH = phr_pkg::MIN_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  phr_pkg::t_phr_in    i_item,
    output logic                o_tok_wr,
    output phr_pkg::t_phr_token o_tok
);

    localparam int unsigned LW = phr_pkg::LEN_W;

    logic          r_idle;
    logic [LW-1:0] r_count, r_len;
    logic [LW-1:0] len_eff, cnt_inc;
    logic [7:0]    b;
    logic          accept, last;

    assign b       = i_item.byte_value;
    assign accept  = i_push && !i_full;
    assign len_eff = (i_item.stream_length == '0) ? LW'(1) : i_item.stream_length;
    assign cnt_inc = r_count + LW'(1);
    assign last    = r_idle ? (len_eff == LW'(1)) : (cnt_inc == r_len);

    always_comb begin
        o_tok.cls.is_ws    = (b == phr_pkg::CH_SPACE) || (b == phr_pkg::CH_TAB)
                          || (b == phr_pkg::CH_CR) || (b == phr_pkg::CH_LF);
        o_tok.cls.is_nl    = (b == phr_pkg::CH_LF);
        o_tok.cls.is_hash  = (b == phr_pkg::CH_HASH);
        o_tok.cls.is_digit = (b >= phr_pkg::CH_ZERO) && (b <= phr_pkg::CH_NINE);
        o_tok.cls.is_fmt   = (b >= phr_pkg::CH_ONE) && (b <= phr_pkg::CH_SIX);
        o_tok.cls.is_p     = (b == phr_pkg::CH_P);
        o_tok.cls.is_bom0  = (b == phr_pkg::CH_BOM0);
        o_tok.cls.is_bom1  = (b == phr_pkg::CH_BOM1);
        o_tok.cls.is_bom2  = (b == phr_pkg::CH_BOM2);
        o_tok.digit        = b[3:0];
        o_tok.first        = r_idle;
        o_tok.last         = last;
        o_tok.short_len    = i_item.stream_length < LW'(MIN_LENGTH);
        o_tok.bom_ok       = i_item.stream_length >= LW'(phr_pkg::BOM_LEN);
        o_tok.idx          = r_idle ? '0 : r_count;
        o_tok.len          = r_idle ? len_eff : r_len;
    end

    assign o_tok_wr = i_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle  <= 1'b1;
            r_count <= '0;
            r_len   <= '0;
        end else if (accept) begin
            r_idle  <= last;
            r_count <= last ? '0 : (r_idle ? LW'(1) : cnt_inc);
            if (r_idle) begin
                r_len <= len_eff;
            end
        end
    end

    a_count_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_idle |-> (r_count != '0 && r_count < r_len))
        else $error("phr_front: byte count outside image length");

endmodule

// ===== rtl/core/phr_back.sv =====
// ----------------------------------------------------------------------------
// phr_back: header parser state machine
// walks bom, magic, numbers and tail one token a cycle while i_out_ready is high, gives one outcome
// ----------------------------------------------------------------------------
module phr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tok_valid,
    input  phr_pkg::t_phr_token   i_tok,
    input  logic                  i_out_ready,
    output logic                  o_tok_pop,
    output logic                  o_oc_valid,
    output phr_pkg::t_phr_outcome o_oc
);

    localparam int unsigned NW = phr_pkg::NUM_W;
    localparam int unsigned LW = phr_pkg::LEN_W;

    phr_pkg::t_phr_phase r_phase, n_phase;
    logic          r_comment, n_comment;
    logic          r_seen, n_seen;
    logic          r_sent, n_sent;
    logic [NW-1:0] r_acc, n_acc;
    logic [NW-1:0] r_w, n_w, r_h, n_h, r_m, n_m;
    logic [2:0]    r_fmt, n_fmt;
    logic          emit;

    // {skip, comment flag after this byte}
    function automatic logic [1:0] skip_fn(input logic cm, input phr_pkg::t_phr_class c);
        logic [1:0] r;
        if (cm) begin
            r = {1'b1, !c.is_nl};
        end else if (c.is_hash) begin
            r = 2'b11;
        end else begin
            r = {c.is_ws, 1'b0};
        end
        return r;
    endfunction

    function automatic logic is_pbm(input logic [2:0] f);
        return (f == phr_pkg::FMT_P1) || (f == phr_pkg::FMT_P4);
    endfunction

    assign o_tok_pop = i_tok_valid && i_out_ready;

    always_comb begin
        logic          fin, redo, skip, sk_cm, do_proc, ok;
        logic [NW+3:0] acc_x;
        logic [2:0]    err;
        logic [LW-1:0] hl;

        n_phase   = r_phase;
        n_comment = r_comment;
        n_seen    = r_seen;
        n_sent    = r_sent;
        n_acc     = r_acc;
        n_w       = r_w;
        n_h       = r_h;
        n_m       = r_m;
        n_fmt     = r_fmt;
        emit      = 1'b0;
        fin       = 1'b0;
        redo      = 1'b0;
        skip      = 1'b0;
        sk_cm     = 1'b0;
        ok        = 1'b0;
        err       = phr_pkg::ERR_NONE;
        hl        = i_tok.idx;
        acc_x     = '0;
        do_proc   = 1'b1;

        // first byte of an image starts from a clean slate
        if (i_tok.first) begin
            n_comment = 1'b0;
            n_seen    = 1'b0;
            n_sent    = 1'b0;
            n_acc     = '0;
            n_w       = '0;
            n_h       = '0;
            n_m       = '0;
            n_fmt     = '0;
            if (i_tok.short_len) begin
                emit    = 1'b1;
                err     = phr_pkg::ERR_SHORT;
                n_phase = phr_pkg::PH_DONE;
                do_proc = 1'b0;
            end else if (i_tok.cls.is_bom0 && i_tok.bom_ok) begin
                n_phase = phr_pkg::PH_BOM1;
                do_proc = 1'b0;
            end else begin
                n_phase = phr_pkg::PH_PRE;
            end
        end

        if (do_proc) begin
            unique case (n_phase)
                phr_pkg::PH_BOM1: begin
                    if (i_tok.cls.is_bom1) begin
                        n_phase = phr_pkg::PH_BOM2;
                    end else begin
                        emit = 1'b1; err = phr_pkg::ERR_MAGIC; n_phase = phr_pkg::PH_DONE;
                    end
                end
                phr_pkg::PH_BOM2: begin
                    if (i_tok.cls.is_bom2) begin
                        n_phase = phr_pkg::PH_PRE;
                    end else begin
                        emit = 1'b1; err = phr_pkg::ERR_MAGIC; n_phase = phr_pkg::PH_DONE;
                    end
                end
                phr_pkg::PH_PRE: begin
                    {skip, sk_cm} = skip_fn(n_comment, i_tok.cls);
                    n_comment = sk_cm;
                    if (!skip) begin
                        if (i_tok.cls.is_p) begin
                            n_phase = phr_pkg::PH_DIGIT;
                        end else begin
                            emit = 1'b1; err = phr_pkg::ERR_MAGIC;
                            n_phase = phr_pkg::PH_DONE;
                        end
                    end
                end
                phr_pkg::PH_DIGIT: begin
                    if (i_tok.cls.is_fmt) begin
                        n_fmt   = i_tok.digit[2:0];
                        n_phase = phr_pkg::PH_WIDTH;
                    end else begin
                        emit = 1'b1; err = phr_pkg::ERR_DIGIT; n_phase = phr_pkg::PH_DONE;
                    end
                end
                phr_pkg::PH_WIDTH, phr_pkg::PH_HEIGHT, phr_pkg::PH_MAXVAL: begin
                    if (!n_seen) begin
                        {skip, sk_cm} = skip_fn(n_comment, i_tok.cls);
                        n_comment = sk_cm;
                    end
                    if (!skip) begin
                        if (i_tok.cls.is_digit) begin
                            // acc * 10 + digit
                            acc_x  = {1'b0, n_acc, 3'b000} + {3'b000, n_acc, 1'b0}
                                   + (NW+4)'(i_tok.digit);
                            n_seen = 1'b1;
                            n_acc  = acc_x[NW-1:0];
                            if (acc_x[NW+3:NW] != 4'd0) begin
                                emit = 1'b1; err = phr_pkg::ERR_LARGE;
                                n_phase = phr_pkg::PH_DONE;
                            end
                        end else if (!n_seen) begin
                            emit = 1'b1; err = phr_pkg::ERR_MISSING;
                            n_phase = phr_pkg::PH_DONE;
                        end else begin
                            // number ends here, byte goes on to the next phase
                            if (n_phase == phr_pkg::PH_WIDTH) begin
                                n_w     = n_acc;
                                n_phase = phr_pkg::PH_HEIGHT;
                            end else if (n_phase == phr_pkg::PH_HEIGHT) begin
                                n_h     = n_acc;
                                n_phase = is_pbm(n_fmt) ? phr_pkg::PH_TAIL
                                                        : phr_pkg::PH_MAXVAL;
                            end else begin
                                n_m     = n_acc;
                                n_phase = phr_pkg::PH_TAIL;
                            end
                            n_acc     = '0;
                            n_seen    = 1'b0;
                            n_comment = 1'b0;
                            redo      = 1'b1;
                        end
                    end
                end
                phr_pkg::PH_TAIL: begin
                    {skip, sk_cm} = skip_fn(n_comment, i_tok.cls);
                    n_comment = sk_cm;
                    if (!skip) begin
                        fin = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // second look at the byte that ended a number
        if (redo) begin
            {skip, sk_cm} = skip_fn(1'b0, i_tok.cls);
            n_comment = sk_cm;
            if (!skip) begin
                if (n_phase == phr_pkg::PH_TAIL) begin
                    fin = 1'b1;
                end else begin
                    emit = 1'b1; err = phr_pkg::ERR_MISSING; n_phase = phr_pkg::PH_DONE;
                end
            end
        end

        // end of buffer without an outcome yet
        if (i_tok.last && !emit && !fin && !n_sent) begin
            unique case (n_phase)
                phr_pkg::PH_WIDTH, phr_pkg::PH_HEIGHT, phr_pkg::PH_MAXVAL: begin
                    if (n_seen && n_phase == phr_pkg::PH_HEIGHT && is_pbm(n_fmt)) begin
                        n_h = n_acc;
                        fin = 1'b1;
                        hl  = i_tok.len;
                    end else if (n_seen && n_phase == phr_pkg::PH_MAXVAL) begin
                        n_m = n_acc;
                        fin = 1'b1;
                        hl  = i_tok.len;
                    end else begin
                        emit = 1'b1; err = phr_pkg::ERR_MISSING;
                    end
                end
                phr_pkg::PH_TAIL: begin
                    fin = 1'b1;
                    hl  = i_tok.len;
                end
                default: begin
                    emit = 1'b1; err = phr_pkg::ERR_MAGIC;
                end
            endcase
        end

        // finish: pbm has an implied maxval of one, zeros are rejected
        if (fin) begin
            if (is_pbm(n_fmt)) begin
                n_m = NW'(1);
            end
            emit    = 1'b1;
            n_phase = phr_pkg::PH_DONE;
            if (n_w == '0 || n_h == '0 || n_m == '0) begin
                err = phr_pkg::ERR_ZERO;
            end else begin
                ok = 1'b1;
            end
        end

        n_sent = n_sent || emit;
        if (i_tok.last) begin
            n_phase = phr_pkg::PH_IDLE;
        end

        o_oc.ok  = ok;
        o_oc.err = err;
        o_oc.fmt = n_fmt;
        o_oc.w   = ok ? n_w : '0;
        o_oc.h   = ok ? n_h : '0;
        o_oc.m   = ok ? n_m : '0;
        o_oc.hl  = ok ? hl : '0;
    end

    assign o_oc_valid = o_tok_pop && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= phr_pkg::PH_IDLE;
            r_comment <= 1'b0;
            r_seen    <= 1'b0;
            r_sent    <= 1'b0;
        end else if (o_tok_pop) begin
            r_phase   <= n_phase;
            r_comment <= n_comment;
            r_seen    <= n_seen;
            r_sent    <= n_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop) begin
            r_acc <= n_acc;
            r_w   <= n_w;
            r_h   <= n_h;
            r_m   <= n_m;
            r_fmt <= n_fmt;
        end
    end

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_oc_valid |-> (i_tok.first || !r_sent))
        else $error("phr_back: second outcome for one image");

    a_done_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == phr_pkg::PH_DONE) |-> r_sent)
        else $error("phr_back: done phase without outcome");

endmodule

// ===== rtl/core/phr_size.sv =====
// ----------------------------------------------------------------------------
// phr_size: data size stage
// registered width by height product, then per format scaling to result word
// ----------------------------------------------------------------------------
module phr_size (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  phr_pkg::t_phr_outcome i_oc,
    output logic                  o_ready,
    input  logic                  i_full,
    output logic                  o_wr,
    output phr_pkg::t_phr_out     o_result
);

    localparam int unsigned NW = phr_pkg::NUM_W;
    localparam int unsigned PW = phr_pkg::PROD_W;
    localparam int unsigned DW = phr_pkg::DATA_W;

    logic                  r_valid;
    phr_pkg::t_phr_outcome r_oc;
    logic [PW-1:0]         r_prod;
    logic [NW-1:0]         a;
    logic [PW-1:0]         prod;
    logic [DW-1:0]         p, dl;
    logic [1:0]            mode;

    // raw pbm (P4) packs eight pixels per byte: ceil(w / 8)
    assign a = (i_oc.fmt == phr_pkg::FMT_P4)
             ? ({3'b000, i_oc.w[NW-1:3]} + {{(NW-1){1'b0}}, |i_oc.w[2:0]})
             : i_oc.w;
    assign prod = a * i_oc.h;

    assign o_ready = !r_valid || !i_full;
    assign o_wr    = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_oc   <= i_oc;
            r_prod <= prod;
        end
    end

    assign p = DW'(r_prod);

    always_comb begin
        case (r_oc.fmt) inside
            phr_pkg::FMT_P4: dl = p;
            phr_pkg::FMT_P1: dl = p << 1;
            phr_pkg::FMT_P5: dl = (r_oc.m > phr_pkg::SAMPLE_8BIT_MAX) ? (p << 1) : p;
            phr_pkg::FMT_P2: dl = p << 2;
            phr_pkg::FMT_P6: dl = (p << 1) + p;
            default:         dl = (p << 3) + (p << 2);
        endcase
        case (r_oc.fmt) inside
            phr_pkg::FMT_P1, phr_pkg::FMT_P4: mode = phr_pkg::MODE_MONO;
            phr_pkg::FMT_P2, phr_pkg::FMT_P5: mode = phr_pkg::MODE_GRAY;
            default:                          mode = phr_pkg::MODE_RGB;
        endcase
    end

    always_comb begin
        o_result.header_ok     = r_oc.ok;
        o_result.error_code    = r_oc.err;
        o_result.format_digit  = r_oc.fmt;
        o_result.raw_format    = r_oc.ok && (r_oc.fmt >= phr_pkg::FMT_P4);
        o_result.color_kind    = r_oc.ok ? mode : phr_pkg::MODE_MONO;
        o_result.image_width   = r_oc.w;
        o_result.image_height  = r_oc.h;
        o_result.max_sample    = r_oc.m;
        o_result.header_length = r_oc.hl;
        o_result.data_length   = r_oc.ok ? dl : '0;
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> o_ready)
        else $error("phr_size: outcome offered while stage blocked");

endmodule

// ===== rtl/core/pnm_header_parser.sv =====
// ----------------------------------------------------------------------------
// pnm_header_parser: netpbm header parser
// takes image bytes one word per cycle while full is low and gives one outcome word per image
// ----------------------------------------------------------------------------
// The block takes one byte word per cycle with no gaps of its own: push may
// stay high for a whole image and full only rises when the result side is
// backed up long enough to fill the byte queue. Each image gives exactly one
// outcome word, which shows on o_result once the byte that decides it has
// passed the byte queue, the size stage register and the result queue; bytes
// after the outcome are taken and dropped until the latched length is used
// up. The sustained rate is one byte per cycle while the result side keeps
// up, set by the parser state machine that handles one classified byte per
// cycle. There is no clearing pass after reset. The stream_length of the
// first byte of each image is the one used.
// ----------------------------------------------------------------------------
module pnm_header_parser #(
    parameter int unsigned MIN_LENGTH   = phr_pkg::MIN_LENGTH,
    parameter int unsigned TOKEN_DEPTH  = phr_pkg::TOKEN_DEPTH,
    parameter int unsigned RESULT_DEPTH = phr_pkg::RESULT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte side
    input  logic              push,
    output logic              full,
    input  phr_pkg::t_phr_in  i_item,
    // result side
    output logic              empty,
    input  logic              pop,
    output phr_pkg::t_phr_out o_result
);

    // front to back token queue
    phr_pkg::t_phr_token tok_in, tok_out;
    logic                tok_wr, tok_full, tok_empty, tok_pop;
    logic [$bits(phr_pkg::t_phr_token)-1:0] tok_q;

    // back to size stage
    phr_pkg::t_phr_outcome oc;
    logic                  oc_valid, size_ready;

    // size stage to result queue
    phr_pkg::t_phr_out res_in;
    logic              res_wr, res_full;
    logic [$bits(phr_pkg::t_phr_out)-1:0] res_q;

    // classify the byte and track where it sits in the image
    phr_front #(
        .MIN_LENGTH (MIN_LENGTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_full   (tok_full),
        .i_item   (i_item),
        .o_tok_wr (tok_wr),
        .o_tok    (tok_in)
    );

    assign full = tok_full;

    // short queue that decouples byte intake from parsing
    phr_queue #(
        .WIDTH ($bits(phr_pkg::t_phr_token)),
        .DEPTH (TOKEN_DEPTH)
    ) u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_wr),
        .i_data  (tok_in),
        .o_full  (tok_full),
        .i_pop   (tok_pop),
        .o_data  (tok_q),
        .o_empty (tok_empty)
    );

    assign tok_out = phr_pkg::t_phr_token'(tok_q);

    // header state machine, one token per cycle while the size stage has room
    phr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!tok_empty),
        .i_tok       (tok_out),
        .i_out_ready (size_ready),
        .o_tok_pop   (tok_pop),
        .o_oc_valid  (oc_valid),
        .o_oc        (oc)
    );

    // width x height product and per format data size
    phr_size u_size (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (oc_valid),
        .i_oc     (oc),
        .o_ready  (size_ready),
        .i_full   (res_full),
        .o_wr     (res_wr),
        .o_result (res_in)
    );

    // result words wait here for pop
    phr_queue #(
        .WIDTH ($bits(phr_pkg::t_phr_out)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_wr),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_result = phr_pkg::t_phr_out'(res_q);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: netpbm header parser check
// feeds byte words of whole images, directed corner cases first and then
// random headers, and compares every outcome word with a local prediction
// ----------------------------------------------------------------------------
module testbench;

    import phr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_WAIT   = 20;

    // ------------------------------------------------------------------------
    // outcome prediction and checking
    // ------------------------------------------------------------------------
    class header_outcome_board;
        // parser state as seen from outside
        t_phr_phase      ph;
        int unsigned     nbytes;
        int unsigned     img_len;
        bit              in_cmt;
        bit              got_digit;
        int unsigned     acc;
        bit [2:0]        fmt;
        longint unsigned wid;
        longint unsigned hgt;
        longint unsigned mxv;
        bit              sent;

        t_phr_out        outcomes_due[$];
        int unsigned     mismatches;
        int unsigned     checked;
        int unsigned     by_code[8];

        function new();
            ph = PH_IDLE;
        endfunction

        function void give_fail(logic [2:0] err);
            t_phr_out r;
            r = '0;
            r.error_code   = err;
            r.format_digit = fmt;
            outcomes_due.push_back(r);
            sent = 1'b1;
            ph = PH_DONE;
        endfunction

        function void give_done(logic [LEN_W-1:0] hl);
            t_phr_out        r;
            longint unsigned area;
            // pbm has no maxval field
            if (fmt == FMT_P1 || fmt == FMT_P4) mxv = 1;
            if (wid == 0 || hgt == 0 || mxv == 0) begin
                give_fail(ERR_ZERO);
                return;
            end
            area = wid * hgt;
            r = '0;
            r.header_ok     = 1'b1;
            r.format_digit  = fmt;
            r.raw_format    = (fmt >= FMT_P4);
            r.image_width   = NUM_W'(wid);
            r.image_height  = NUM_W'(hgt);
            r.max_sample    = NUM_W'(mxv);
            r.header_length = hl;
            case (fmt)
                FMT_P4: begin
                    r.data_length = DATA_W'(((wid + 7) / 8) * hgt);
                    r.color_kind  = MODE_MONO;
                end
                FMT_P1: begin
                    r.data_length = DATA_W'(area * 2);
                    r.color_kind  = MODE_MONO;
                end
                FMT_P5: begin
                    r.data_length = DATA_W'(area * ((mxv > SAMPLE_8BIT_MAX) ? 2 : 1));
                    r.color_kind  = MODE_GRAY;
                end
                FMT_P2: begin
                    r.data_length = DATA_W'(area * 4);
                    r.color_kind  = MODE_GRAY;
                end
                FMT_P6: begin
                    r.data_length = DATA_W'(area * 3);
                    r.color_kind  = MODE_RGB;
                end
                default: begin
                    r.data_length = DATA_W'(area * 12);
                    r.color_kind  = MODE_RGB;
                end
            endcase
            outcomes_due.push_back(r);
            sent = 1'b1;
            ph = PH_DONE;
        endfunction

        // whitespace and comments; a comment runs up to a line feed
        function bit skip_byte(logic [7:0] b);
            if (in_cmt) begin
                if (b == CH_LF) in_cmt = 1'b0;
                return 1'b1;
            end
            if (b == CH_HASH) begin
                in_cmt = 1'b1;
                return 1'b1;
            end
            return (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF);
        endfunction

        // keeps a finished number, tells whether it was the last one
        function bit store_num();
            bit last;
            last = 1'b0;
            case (ph)
                PH_WIDTH: begin
                    wid = acc;
                    ph = PH_HEIGHT;
                end
                PH_HEIGHT: begin
                    hgt = acc;
                    last = (fmt == FMT_P1 || fmt == FMT_P4);
                    if (last) ph = PH_TAIL;
                    else ph = PH_MAXVAL;
                end
                default: begin
                    mxv = acc;
                    last = 1'b1;
                    ph = PH_TAIL;
                end
            endcase
            acc = 0;
            got_digit = 1'b0;
            in_cmt = 1'b0;
            return last;
        endfunction

        function void step_byte(logic [7:0] b);
            // a byte that ends a number is looked at again by the next phase
            for (int pass = 0; pass < 2; pass++) begin
                case (ph)
                    PH_BOM1: begin
                        if (b != CH_BOM1) give_fail(ERR_MAGIC);
                        else ph = PH_BOM2;
                        return;
                    end
                    PH_BOM2: begin
                        if (b != CH_BOM2) give_fail(ERR_MAGIC);
                        else ph = PH_PRE;
                        return;
                    end
                    PH_PRE: begin
                        if (!skip_byte(b)) begin
                            if (b == CH_P) ph = PH_DIGIT;
                            else give_fail(ERR_MAGIC);
                        end
                        return;
                    end
                    PH_DIGIT: begin
                        if (b >= CH_ONE && b <= CH_SIX) begin
                            fmt = 3'(b - CH_ZERO);
                            ph = PH_WIDTH;
                        end else begin
                            give_fail(ERR_DIGIT);
                        end
                        return;
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                        if (!got_digit && skip_byte(b)) return;
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            acc = acc * 10 + (b - CH_ZERO);
                            got_digit = 1'b1;
                            if (acc >= (1 << NUM_W)) give_fail(ERR_LARGE);
                            return;
                        end
                        if (!got_digit) begin
                            give_fail(ERR_MISSING);
                            return;
                        end
                        void'(store_num());
                    end
                    PH_TAIL: begin
                        if (!skip_byte(b)) give_done(LEN_W'(nbytes));
                        return;
                    end
                    default: return;
                endcase
            end
        endfunction

        function void end_of_image();
            case (ph)
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                    if (got_digit && store_num()) give_done(LEN_W'(img_len));
                    else give_fail(ERR_MISSING);
                end
                PH_TAIL: give_done(LEN_W'(img_len));
                default: give_fail(ERR_MAGIC);
            endcase
        endfunction

        // one accepted byte word
        function void take_byte(t_phr_in w);
            logic [7:0]       b;
            logic [LEN_W-1:0] len;
            b   = w.byte_value;
            len = w.stream_length;
            if (ph == PH_IDLE) begin
                // first byte of an image latches the length
                nbytes = 0;
                in_cmt = 1'b0;
                acc = 0;
                got_digit = 1'b0;
                fmt = '0;
                wid = 0;
                hgt = 0;
                mxv = 0;
                sent = 1'b0;
                img_len = (len == 0) ? 1 : len;
                ph = PH_PRE;
                if (len < MIN_LENGTH) give_fail(ERR_SHORT);
                else if (b == CH_BOM0 && len >= BOM_LEN) ph = PH_BOM1;
                else step_byte(b);
            end else begin
                step_byte(b);
            end
            nbytes++;
            if (nbytes >= img_len) begin
                if (!sent) end_of_image();
                ph = PH_IDLE;
            end
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_outcome(t_phr_out got);
            t_phr_out want;
            if (outcomes_due.size() == 0) begin
                $error("outcome word with none expected");
                mismatches++;
                return;
            end
            want = outcomes_due.pop_front();
            checked++;
            by_code[want.error_code]++;
            compare("header_ok", want.header_ok, got.header_ok);
            compare("error_code", want.error_code, got.error_code);
            compare("format_digit", want.format_digit, got.format_digit);
            compare("raw_format", want.raw_format, got.raw_format);
            compare("color_kind", want.color_kind, got.color_kind);
            compare("image_width", want.image_width, got.image_width);
            compare("image_height", want.image_height, got.image_height);
            compare("max_sample", want.max_sample, got.max_sample);
            compare("header_length", want.header_length, got.header_length);
            compare("data_length", want.data_length, got.data_length);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, signals and the block
    // ------------------------------------------------------------------------
    logic     clk = 1'b0;
    logic     rst_n;
    logic     push;
    logic     full;
    t_phr_in  i_item;
    logic     empty;
    logic     pop;
    t_phr_out o_result;

    // idle switches for both sides and the request for a long result hold
    bit src_idle;
    bit sink_idle;
    bit hold_req;

    int unsigned bytes_sent;
    int unsigned images_sent;

    header_outcome_board board = new();

    initial begin : clock_gen
        forever #4 clk = ~clk;
    end

    pnm_header_parser dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // ------------------------------------------------------------------------
    // header text builders for the random part
    // ------------------------------------------------------------------------

    // leading byte order mark in front of the given text
    function automatic string with_bom(string rest);
        string s;
        s = {"...", rest};
        s[0] = CH_BOM0;
        s[1] = CH_BOM1;
        s[2] = CH_BOM2;
        return s;
    endfunction

    // run of separators: blanks, line ends and comments with content bytes 11 to 255
    function automatic string gap_text(int unsigned min_n);
        string s;
        int unsigned n;
        s = "";
        n = $urandom_range(2) + min_n;
        repeat (n) begin
            case ($urandom_range(9))
                0, 1, 2, 3: s = {s, " "};
                4: s = {s, "\t"};
                5: s = {s, "\r"};
                6, 7: s = {s, "\n"};
                default: begin
                    s = {s, "#"};
                    repeat ($urandom_range(6))
                        s = $sformatf("%s%c", s, 8'($urandom_range(255, 11)));
                    s = {s, "\n"};
                end
            endcase
        end
        return s;
    endfunction

    // mostly small values, with zero, the largest and too large mixed in
    function automatic string num_text();
        int unsigned r;
        int unsigned v;
        string s;
        r = $urandom_range(99);
        if (r < 5) v = 0;
        else if (r < 12) v = 65535;
        else if (r < 17) v = $urandom_range(99999, 65536);
        else if (r < 60) v = $urandom_range(20, 1);
        else v = $urandom_range(1000, 1);
        s = $sformatf("%0d", v);
        if (r % 9 == 0) s = {"0", s};
        return s;
    endfunction

    function automatic string random_header();
        int unsigned r;
        int unsigned nnum;
        int unsigned dig;
        string s;
        r = $urandom_range(99);
        s = "";
        // plain noise
        if (r < 8) begin
            repeat ($urandom_range(12, 1))
                s = $sformatf("%s%c", s, 8'($urandom_range(255, 1)));
            return s;
        end
        dig = $urandom_range(6, 1);
        s = {gap_text(0), "P"};
        // a stray byte where the format digit belongs
        if (r >= 95) s = $sformatf("%s%c", s, 8'($urandom_range(255, 1)));
        else s = $sformatf("%s%0d", s, dig);
        nnum = (dig == 1 || dig == 4) ? 2 : 3;
        for (int unsigned k = 0; k < nnum; k++)
            s = {s, gap_text((k == 0) ? 0 : 1), num_text()};
        s = {s, gap_text(1)};
        // one corrupted byte somewhere
        if (r >= 88 && r < 95) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255, 1));
        if (r < 18) s = with_bom(s);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------------

    // one byte word; called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] len);
        t_phr_in w;
        w.byte_value    = b;
        w.stream_length = len;
        while (src_idle && $urandom_range(99) < 36) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push   <= 1'b1;
        i_item <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        board.take_byte(w);
        bytes_sent++;
        @(negedge clk);
    endtask

    // whole image: header text, then random bytes up to the length;
    // cut stops early for lengths too long to send in full
    task automatic send_image(input string hdr, input int unsigned len,
                              input int unsigned cut = 0);
        int unsigned n;
        n = (len == 0) ? 1 : len;
        if (cut != 0 && cut < n) n = cut;
        for (int unsigned k = 0; k < n; k++)
            send_byte((k < hdr.len()) ? hdr[k] : 8'($urandom_range(255)), LEN_W'(len));
        images_sent++;
    endtask

    // sender stops until every predicted outcome word has come out
    task automatic drain();
        push <= 1'b0;
        while (board.outcomes_due.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_image();
        string       hdr;
        int unsigned r;
        int unsigned len;
        hdr = random_header();
        r = $urandom_range(99);
        // truncated buffers, a few longer ones, otherwise a short data tail
        if (r < 12) len = $urandom_range(hdr.len(), 1);
        else if (r < 15) len = $urandom_range(300, 64);
        else len = hdr.len() + $urandom_range(6);
        send_image(hdr, len);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        string bad_bom;
        rst_n     = 1'b0;
        push      = 1'b0;
        i_item    = '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        hold_req  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every format, with the size rules of each
        send_image("P1 3 2\n", 12);
        send_image("P4\n9 2\n", 16);
        send_image("P2 4 4 255\n", 16);
        send_image("P5 2 2 256\n", 14);
        send_image("P3 1 1 1\n", 12);
        send_image("P6\n#c\n65535 65535 65535\n", 30);
        // largest data size there is
        send_image("P3 65535 65535 65535\n", 24);
        // byte order mark, whole and broken
        send_image(with_bom("P6 2 3 7\n"), 16);
        bad_bom = with_bom("P1 1 1\n");
        bad_bom[2] = "x";
        send_image(bad_bom, 12);
        // short buffers, zero length counts as one byte
        send_image("P1 1 1\n", 9);
        send_image("", 0);
        send_image("P1 1 1\n", 1);
        // bad magic, also after a comment and when the buffer ends after p
        send_image("Q1 1 1\n", 12);
        send_image("  # hi\nX 1 1\n", 14);
        send_image("\t\r\n       P", 11);
        // unsupported digit
        send_image("P7 1 1\n", 12);
        // missing number, inside the buffer and at its end
        send_image("P2 x 1 1\n", 12);
        send_image("P2 3      ", 10);
        // too large and zero values
        send_image("P1 65536 1\n", 14);
        send_image("P5 1 1 0\n", 12);
        // buffer ends in the tail comment, or right on the last number
        send_image("P1 5 5 # tail", 13);
        send_image("P2 1 2 3456", 11);
        // comments between and right after numbers
        send_image("P2 #x\n 5#y\n6 7\n", 20);

        while (bytes_sent < 350) random_image();

        // pause until everything is out
        drain();

        // result side holds off while bytes keep coming, so full must rise
        hold_req = 1'b1;
        src_idle = 1'b0;
        repeat (8) random_image();
        drain();

        // stretch with no idling on either side
        sink_idle = 1'b0;
        repeat (10) random_image();
        src_idle  = 1'b1;
        sink_idle = 1'b1;

        while (bytes_sent < 740 || images_sent < 40) random_image();
        drain();

        // full-range length: only the header and a few bytes are sent,
        // the outcome comes at the first data byte
        send_image("P5 65535 65535 65535\nX", 24'hFFFFFF, 28);

        drain();
        repeat (TAIL_WAIT) @(posedge clk);
        $display("covered %0d byte words in %0d images, %0d outcome words checked",
                 bytes_sent, images_sent, board.checked);
        $display("parsed %0d; short %0d, magic %0d, digit %0d, missing %0d, zero %0d, large %0d",
                 board.by_code[ERR_NONE], board.by_code[ERR_SHORT],
                 board.by_code[ERR_MAGIC], board.by_code[ERR_DIGIT],
                 board.by_code[ERR_MISSING], board.by_code[ERR_ZERO],
                 board.by_code[ERR_LARGE]);
        if (board.mismatches == 0 && board.outcomes_due.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin : result_side
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            // long hold, counted here so the sender runs free meanwhile
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            pop <= !(sink_idle && $urandom_range(99) < 36);
            @(posedge clk);
            if (pop && !empty) board.check_outcome(o_result);
        end
    end

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench failed");
        $finish;
    end

endmodule
